// ===== sv/assert_macros.svh =====
// Assertion macros used by the controller module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define BCE_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/bce_pkg.sv =====
// Package of the ball cluster extent classifier: types, constants and codes.
package bce_pkg;

  localparam int unsigned MaxBallsDefault = 32;
  localparam int unsigned EdgeW = 13;
  localparam int unsigned OutW  = 12;

  typedef logic signed [EdgeW-1:0] edge_t;

  localparam edge_t TopReset = edge_t'(4095);

  typedef enum logic [1:0] {
    RegCenterHalfRange = 2'd0,
    RegEdgeGap         = 2'd1,
    RegImageWidth      = 2'd2,
    RegUpperLimit      = 2'd3
  } reg_idx_e;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StStart  = 6'b000010,
    StRead   = 6'b000100,
    StDrain  = 6'b001000,
    StCommit = 6'b010000,
    StFinish = 6'b100000
  } state_e;

  // Commands from the controller to the datapath (address travels beside).
  typedef struct packed {
    logic load;        // store the accepted request
    logic scan_begin;  // forget the best candidate before a scan
    logic phase_init;  // start the left-edge ordering
    logic phase_next;  // switch to the right-edge ordering
    logic rd_en;       // read one stored ball
    logic commit;      // take the best candidate as next in order
    logic save_lbr;    // keep the left chain result
    logic finish;      // write the result register, clear the frame
  } cmd_t;

  function automatic logic [OutW-1:0] sat12(input edge_t v);
    logic [OutW-1:0] r;
    if (v > edge_t'(2047)) r = 12'h7FF;
    else if (v < -edge_t'(2048)) r = 12'h800;
    else r = v[OutW-1:0];
    return r;
  endfunction

endpackage

// ===== sv/bce_datapath.sv =====
// Datapath: configuration, edge store, frame flags, ordered scan and chain walk.
module bce_datapath #(
  parameter int unsigned MaxBalls = bce_pkg::MaxBallsDefault,
  parameter int unsigned IdxW     = (MaxBalls > 1) ? $clog2(MaxBalls) : 1,
  parameter int unsigned CntW     = $clog2(MaxBalls + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [10:0]     cfg_data_i,
  input  logic [31:0]     in_data_i,
  input  bce_pkg::cmd_t   cmd_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [CntW-1:0] count_o,
  output logic            walk_break_o,
  output logic [31:0]     out_data_o
);

  logic [9:0]  chr_q;
  logic [7:0]  gap_q;
  logic [10:0] iw_q;
  logic [10:0] ul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_q <= 10'd160;
      gap_q <= 8'd5;
      iw_q  <= 11'd640;
      ul_q  <= 11'd440;
    end else if (cfg_we_i) begin
      unique case (bce_pkg::reg_idx_e'(cfg_idx_i))
        bce_pkg::RegCenterHalfRange: chr_q <= cfg_data_i[9:0];
        bce_pkg::RegEdgeGap:         gap_q <= cfg_data_i[7:0];
        bce_pkg::RegImageWidth:      iw_q  <= cfg_data_i;
        bce_pkg::RegUpperLimit:      ul_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Incoming ball.
  logic [10:0] bx, by;
  logic [9:0]  br;
  assign bx = in_data_i[10:0];
  assign by = in_data_i[21:11];
  assign br = in_data_i[31:22];

  bce_pkg::edge_t x13, left_e, right_e, top_e, c13, lo, hi, g13;
  assign x13     = bce_pkg::edge_t'({2'b0, bx});
  assign left_e  = x13 - bce_pkg::edge_t'({3'b0, br});
  assign right_e = x13 + bce_pkg::edge_t'({3'b0, br});
  assign top_e   = bce_pkg::edge_t'({2'b0, by}) - bce_pkg::edge_t'({3'b0, br});
  assign c13     = bce_pkg::edge_t'({3'b0, iw_q[10:1]});
  assign lo      = c13 - bce_pkg::edge_t'({3'b0, chr_q});
  assign hi      = c13 + bce_pkg::edge_t'({3'b0, chr_q});
  assign g13     = bce_pkg::edge_t'({5'b0, gap_q});

  // Frame state.
  logic [CntW-1:0]   cnt_q;
  bce_pkg::edge_t    top_q;
  logic              f_left_q, f_right_q, f_nl_q, f_nr_q, f_any_q;
  logic [2*bce_pkg::EdgeW-1:0] mem [MaxBalls];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && br != 10'd0 && cnt_q < CntW'(MaxBalls)) begin
      mem[cnt_q[IdxW-1:0]] <= {right_e, left_e};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      top_q     <= bce_pkg::TopReset;
      f_left_q  <= 1'b0;
      f_right_q <= 1'b0;
      f_nl_q    <= 1'b0;
      f_nr_q    <= 1'b0;
      f_any_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      cnt_q     <= '0;
      top_q     <= bce_pkg::TopReset;
      f_left_q  <= 1'b0;
      f_right_q <= 1'b0;
      f_nl_q    <= 1'b0;
      f_nr_q    <= 1'b0;
      f_any_q   <= 1'b0;
    end else if (cmd_i.load && br != 10'd0) begin
      if (cnt_q < CntW'(MaxBalls)) cnt_q <= cnt_q + 1'b1;
      if (top_e < top_q) top_q <= top_e;
      f_any_q <= 1'b1;
      if (x13 >= lo && x13 < lo + g13) f_nl_q <= 1'b1;
      if (x13 < lo) f_left_q <= 1'b1;
      if (x13 <= hi && x13 > hi - g13) f_nr_q <= 1'b1;
      if (x13 > hi) f_right_q <= 1'b1;
    end
  end

  assign count_o = cnt_q;

  // Scan: registered read, then compare against the best candidate.
  logic [2*bce_pkg::EdgeW-1:0] rd_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q     <= mem[rd_addr_i];
      rd_idx_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else         rd_vld_q <= cmd_i.rd_en;
  end

  // The right-edge ordering is descending, so its key is the negated edge.
  logic                 phase_q;
  bce_pkg::edge_t       rd_left, rd_right;
  logic signed [13:0]   sk;
  assign rd_left  = rd_q[bce_pkg::EdgeW-1:0];
  assign rd_right = rd_q[2*bce_pkg::EdgeW-1:bce_pkg::EdgeW];
  assign sk = phase_q ? -{rd_right[12], rd_right} : {rd_left[12], rd_left};

  logic signed [13:0] prev_k_q, best_k_q;
  logic [IdxW-1:0]    prev_i_q;
  logic               prev_vld_q, best_vld_q;
  bce_pkg::edge_t     best_l_q, best_r_q, chain_q, lbr_q, chain_nxt;
  logic               qualify, walk_ok;

  assign qualify = !prev_vld_q || sk > prev_k_q || (sk == prev_k_q && rd_idx_q > prev_i_q);
  assign walk_ok = !prev_vld_q ||
                   (phase_q ? (chain_q <= best_r_q) : (chain_q >= best_l_q));
  assign walk_break_o = !walk_ok;
  assign chain_nxt = walk_ok ? (phase_q ? best_l_q : best_r_q) : chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      prev_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      if (cmd_i.phase_init || cmd_i.phase_next) begin
        phase_q    <= cmd_i.phase_next;
        prev_vld_q <= 1'b0;
      end else if (cmd_i.commit) begin
        prev_vld_q <= 1'b1;
      end
      if (cmd_i.scan_begin) begin
        best_vld_q <= 1'b0;
      end else if (rd_vld_q && qualify && (!best_vld_q || sk < best_k_q)) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && qualify && (!best_vld_q || sk < best_k_q)) begin
      best_k_q <= sk;
      best_l_q <= rd_left;
      best_r_q <= rd_right;
    end
    if (cmd_i.commit) begin
      prev_k_q <= best_k_q;
      chain_q  <= chain_nxt;
    end
    if (cmd_i.save_lbr) lbr_q <= chain_nxt;
  end

  // Index of the best candidate, held apart so the commit can take it.
  logic [IdxW-1:0] best_i_q;
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && qualify && (!best_vld_q || sk < best_k_q)) best_i_q <= rd_idx_q;
    if (cmd_i.commit) prev_i_q <= best_i_q;
  end

  // Result register.
  logic [31:0] res_q;
  logic        above;
  assign above = f_any_q && (top_q > bce_pkg::edge_t'({2'b0, ul_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q[0]     <= f_left_q;
      res_q[1]     <= f_right_q;
      res_q[2]     <= f_nl_q;
      res_q[3]     <= f_nr_q;
      res_q[4]     <= above;
      res_q[5]     <= f_any_q;
      res_q[17:6]  <= (cnt_q != '0) ? bce_pkg::sat12(lbr_q) : 12'd0;
      res_q[29:18] <= (cnt_q != '0) ? bce_pkg::sat12(chain_q) : {1'b0, iw_q};
      res_q[31:30] <= 2'b00;
    end
  end

  assign out_data_o = res_q;

endmodule

// ===== sv/bce_controller.sv =====
// Controller: frame loading, ordering passes, chain walk sequencing and result handshake.
`include "assert_macros.svh"
module bce_controller #(
  parameter int unsigned MaxBalls = bce_pkg::MaxBallsDefault,
  parameter int unsigned IdxW     = (MaxBalls > 1) ? $clog2(MaxBalls) : 1,
  parameter int unsigned CntW     = $clog2(MaxBalls + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic [CntW-1:0] count_i,
  input  logic            walk_break_i,
  output bce_pkg::cmd_t   cmd_o,
  output logic [IdxW-1:0] rd_addr_o
);

  bce_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic [CntW-1:0] pass_q, pass_d;
  logic            phase_q, phase_d;
  logic            ovld_q, ovld_d;
  logic            accept, last_addr;

  assign in_ready_o  = (state_q == bce_pkg::StIdle) && !(in_last_i && ovld_q);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;
  assign rd_addr_o   = addr_q;
  assign last_addr   = ((CntW+1)'(addr_q) == (CntW+1)'(count_i) - 1'b1);

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    pass_d  = pass_q;
    phase_d = phase_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      bce_pkg::StIdle: begin
        cmd_o.load = accept;
        if (accept && in_last_i) state_d = bce_pkg::StStart;
      end
      bce_pkg::StStart: begin
        cmd_o.phase_init = 1'b1;
        cmd_o.scan_begin = 1'b1;
        phase_d = 1'b0;
        pass_d  = '0;
        addr_d  = '0;
        state_d = (count_i == '0) ? bce_pkg::StFinish : bce_pkg::StRead;
      end
      bce_pkg::StRead: begin
        cmd_o.rd_en = 1'b1;
        if (last_addr) state_d = bce_pkg::StDrain;
        else addr_d = addr_q + 1'b1;
      end
      bce_pkg::StDrain: begin
        state_d = bce_pkg::StCommit;
      end
      bce_pkg::StCommit: begin
        cmd_o.commit     = 1'b1;
        cmd_o.scan_begin = 1'b1;
        addr_d = '0;
        if (walk_break_i || pass_q + 1'b1 == count_i) begin
          if (!phase_q) begin
            cmd_o.save_lbr   = 1'b1;
            cmd_o.phase_next = 1'b1;
            phase_d = 1'b1;
            pass_d  = '0;
            state_d = bce_pkg::StRead;
          end else begin
            state_d = bce_pkg::StFinish;
          end
        end else begin
          pass_d  = pass_q + 1'b1;
          state_d = bce_pkg::StRead;
        end
      end
      bce_pkg::StFinish: begin
        cmd_o.finish = 1'b1;
        ovld_d  = 1'b1;
        state_d = bce_pkg::StIdle;
      end
      default: state_d = bce_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bce_pkg::StIdle;
      addr_q  <= '0;
      pass_q  <= '0;
      phase_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      pass_q  <= pass_d;
      phase_q <= phase_d;
      ovld_q  <= ovld_d;
    end
  end

  `BCE_ASSERT(a_ready_idle, !in_ready_o || state_q == bce_pkg::StIdle, "ready outside idle")
  `BCE_ASSERT_NEXT(a_finish_valid, state_q == bce_pkg::StFinish, ovld_q, "result not posted")
  `BCE_ASSERT_NEXT(a_last_starts, accept && in_last_i, state_q == bce_pkg::StStart,
                   "last request did not start ordering")

endmodule

// ===== sv/ball_cluster_extent_classifier.sv =====
// Top level of the ball cluster extent classifier.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: ball_x, ball_y, ball_radius; tlast: last_ball
//  m_axis   | out       | tdata: flags and the two chain extents
//  cfg      | in        | write enable, register index, write data
//
// A ball request is taken while the block is idle. After the
// last request of a frame the stored balls are put in order by repeated
// scans of the edge memory (one entry per cycle through its single read
// port): the left-edge and then the right-edge ordering each run at most
// n passes for a frame of n stored balls; a break in the overlap chain
// ends an ordering early. Reset clears control and frame state at once;
// the edge memory needs no clearing since only entries below the ball
// count are read. The result waits in an output register, and new
// non-last requests are taken while it stalls.
module ball_cluster_extent_classifier #(
  parameter int unsigned MaxBalls = bce_pkg::MaxBallsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: ball_x[10:0], ball_y[21:11], ball_radius[31:22].
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: far_left, far_right, near_left_bound, near_right_bound,
  // above_limit, any_ball, left_chain_right_edge[17:6],
  // right_chain_left_edge[29:18], zero fill.
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned IdxW = (MaxBalls > 1) ? $clog2(MaxBalls) : 1;
  localparam int unsigned CntW = $clog2(MaxBalls + 1);

  bce_pkg::cmd_t   cmd;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] count;
  logic            walk_break;

  bce_controller #(.MaxBalls(MaxBalls), .IdxW(IdxW), .CntW(CntW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .count_i      (count),
    .walk_break_i (walk_break),
    .cmd_o        (cmd),
    .rd_addr_o    (rd_addr)
  );

  bce_datapath #(.MaxBalls(MaxBalls), .IdxW(IdxW), .CntW(CntW)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_data_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .count_o      (count),
    .walk_break_o (walk_break),
    .out_data_o   (m_axis_tdata)
  );

endmodule
